@@ rtl/pdu_dfr_pkg.sv @@
// Package for the PDU stream deframer: section and kind codes, header offsets,
// register indexes and the structs passed between the framer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package pdu_dfr_pkg;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t FIXED_HEADER_BYTES = count_t'(80);
  localparam count_t OFS_CMD = count_t'(3);
  localparam count_t OFS_RID = count_t'(68);
  localparam count_t OFS_SIG = count_t'(72);
  localparam count_t OFS_OPT = count_t'(74);
  localparam count_t OFS_FLAGS = count_t'(75);
  localparam count_t OFS_DLEN = count_t'(76);

  localparam logic [5:0] RECNO_BYTES = 6'd8;
  localparam logic [5:0] SEQNO_BYTES = 6'd8;
  localparam logic [5:0] TIME_BYTES = 6'd16;

  typedef enum logic [1:0] {
    SEC_HDR  = 2'd0,
    SEC_OPT  = 2'd1,
    SEC_DATA = 2'd2,
    SEC_SIG  = 2'd3
  } section_t;

  typedef enum logic [2:0] {
    KIND_HDR  = 3'd0,
    KIND_OPT  = 3'd1,
    KIND_DATA = 3'd2,
    KIND_SIG  = 3'd3,
    KIND_DROP = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_VERSION  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VERSION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VERSION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECNO_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQNO_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_MASK = 3'd4;

  typedef struct packed {
    logic [7:0] min_version;
    logic [7:0] max_version;
    logic [7:0] recno_mask;
    logic [7:0] seqno_mask;
    logic [7:0] time_mask;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic        header_done;
    logic [7:0]  command;
    logic [31:0] request_id;
    logic [31:0] data_length;
    logic [11:0] sig_length;
    logic [3:0]  sig_alg;
    logic [9:0]  option_bytes;
    logic [7:0]  flags;
    err_t        error_code;
    logic        last_of_pdu;
  } result_t;

endpackage

@@ rtl/pdu_dfr_framer.sv @@
// Framing state and per-word decode for the PDU stream deframer.
// Holds the section, byte counter and captured header fields.
// Depends on pdu_dfr_pkg.
`timescale 1ns / 1ps

module pdu_dfr_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  input  pdu_dfr_pkg::cfg_t    cfg,
  output pdu_dfr_pkg::result_t res
);

  localparam int unsigned COUNT_W_P = pdu_dfr_pkg::COUNT_W;

  pdu_dfr_pkg::section_t section, section_next;
  pdu_dfr_pkg::count_t   byte_count, byte_count_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [31:0] request_reg, request_reg_next;
  logic [15:0] sig_word, sig_word_next;
  logic [7:0]  option_words, option_words_next;
  logic [7:0]  flag_reg, flag_reg_next;
  logic [31:0] length_reg, length_reg_next;

  logic [COUNT_W_P:0] count_inc;
  logic [5:0] need;
  logic       show_fields;
  logic       sec_end;

  function automatic pdu_dfr_pkg::section_t advance_to(
    input pdu_dfr_pkg::section_t from,
    input logic [7:0]  opt_w,
    input logic [31:0] len,
    input logic [11:0] sig_len
  );
    pdu_dfr_pkg::section_t s;
    if (from == pdu_dfr_pkg::SEC_HDR && opt_w != 8'd0) begin
      s = pdu_dfr_pkg::SEC_OPT;
    end else if ((from == pdu_dfr_pkg::SEC_HDR || from == pdu_dfr_pkg::SEC_OPT) &&
                 len != 32'd0) begin
      s = pdu_dfr_pkg::SEC_DATA;
    end else if (from != pdu_dfr_pkg::SEC_SIG && sig_len != 12'd0) begin
      s = pdu_dfr_pkg::SEC_SIG;
    end else begin
      s = pdu_dfr_pkg::SEC_HDR;
    end
    return s;
  endfunction

  assign count_inc = {1'b0, byte_count} + {{COUNT_W_P{1'b0}}, 1'b1};

  always_comb begin
    section_next = section;
    byte_count_next = byte_count;
    command_reg_next = command_reg;
    request_reg_next = request_reg;
    sig_word_next = sig_word;
    option_words_next = option_words;
    flag_reg_next = flag_reg;
    length_reg_next = length_reg;
    need = 6'd0;
    show_fields = 1'b1;
    sec_end = 1'b0;

    res = '0;
    res.byte_value = rx_byte;

    unique case (section)
      pdu_dfr_pkg::SEC_OPT: begin
        res.kind = pdu_dfr_pkg::KIND_OPT;
        sec_end = count_inc >= {23'd0, option_words, 2'b00};
      end
      pdu_dfr_pkg::SEC_DATA: begin
        res.kind = pdu_dfr_pkg::KIND_DATA;
        sec_end = count_inc >= {1'b0, length_reg};
      end
      pdu_dfr_pkg::SEC_SIG: begin
        res.kind = pdu_dfr_pkg::KIND_SIG;
        sec_end = count_inc >= {21'd0, sig_word[11:0]};
      end
      pdu_dfr_pkg::SEC_HDR: begin
        if (byte_count == '0 &&
            (rx_byte < cfg.min_version || rx_byte > cfg.max_version)) begin
          res.kind = pdu_dfr_pkg::KIND_DROP;
          res.error_code = pdu_dfr_pkg::ERR_VERSION;
          show_fields = 1'b0;
        end else begin
          res.kind = pdu_dfr_pkg::KIND_HDR;
          if (byte_count == pdu_dfr_pkg::OFS_CMD) begin
            command_reg_next = rx_byte;
          end else if (byte_count >= pdu_dfr_pkg::OFS_RID &&
                       byte_count < pdu_dfr_pkg::OFS_SIG) begin
            request_reg_next = {request_reg[23:0], rx_byte};
          end else if (byte_count >= pdu_dfr_pkg::OFS_SIG &&
                       byte_count < pdu_dfr_pkg::OFS_OPT) begin
            sig_word_next = {sig_word[7:0], rx_byte};
          end else if (byte_count == pdu_dfr_pkg::OFS_OPT) begin
            option_words_next = rx_byte;
          end else if (byte_count == pdu_dfr_pkg::OFS_FLAGS) begin
            flag_reg_next = rx_byte;
          end else if (byte_count >= pdu_dfr_pkg::OFS_DLEN) begin
            length_reg_next = {length_reg[23:0], rx_byte};
          end

          if (count_inc >= {1'b0, pdu_dfr_pkg::FIXED_HEADER_BYTES}) begin
            if ((flag_reg_next & cfg.seqno_mask) != 8'd0) begin
              need = need + pdu_dfr_pkg::SEQNO_BYTES;
            end
            if ((flag_reg_next & cfg.recno_mask) != 8'd0) begin
              need = need + pdu_dfr_pkg::RECNO_BYTES;
            end
            if ((flag_reg_next & cfg.time_mask) != 8'd0) begin
              need = need + pdu_dfr_pkg::TIME_BYTES;
            end
            res.header_done = 1'b1;
            if ({option_words_next, 2'b00} < {4'd0, need}) begin
              res.error_code = pdu_dfr_pkg::ERR_OVERFLOW;
            end
            sec_end = 1'b1;
          end else begin
            show_fields = 1'b0;
            byte_count_next = count_inc[COUNT_W_P-1:0];
          end
        end
      end
    endcase

    if (section != pdu_dfr_pkg::SEC_HDR) begin
      if (sec_end) begin
        byte_count_next = '0;
      end else begin
        byte_count_next = count_inc[COUNT_W_P-1:0];
      end
    end

    if (sec_end) begin
      byte_count_next = '0;
      section_next = advance_to(section, option_words_next, length_reg_next,
                                sig_word_next[11:0]);
      res.last_of_pdu = (section_next == pdu_dfr_pkg::SEC_HDR);
    end

    if (show_fields) begin
      res.command = command_reg_next;
      res.request_id = request_reg_next;
      res.data_length = length_reg_next;
      res.sig_length = sig_word_next[11:0];
      res.sig_alg = sig_word_next[15:12];
      res.option_bytes = {option_words_next, 2'b00};
      res.flags = flag_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section <= pdu_dfr_pkg::SEC_HDR;
      byte_count <= '0;
      command_reg <= '0;
      request_reg <= '0;
      sig_word <= '0;
      option_words <= '0;
      flag_reg <= '0;
      length_reg <= '0;
    end else if (fire) begin
      section <= section_next;
      byte_count <= byte_count_next;
      command_reg <= command_reg_next;
      request_reg <= request_reg_next;
      sig_word <= sig_word_next;
      option_words <= option_words_next;
      flag_reg <= flag_reg_next;
      length_reg <= length_reg_next;
    end
  end

endmodule

@@ rtl/pdu_stream_deframer.sv @@
// Top level of the PDU stream deframer: input word register, configuration
// registers, framer and result register.
// Depends on pdu_dfr_pkg and pdu_dfr_framer.
//
// Channel   Direction  Handshake              Contents
// input     in         in_valid / in_ready    rx_byte
// result    out        out_valid / out_ready  kind, byte_value, decoded header, error_code
// config    in         cfg_write              cfg_index, cfg_data
//
// One word per cycle is sustained while results are taken; an accepted word passes
// through the input register and the framer logic into the result register.
// The input register lets one word be accepted while a result waits to be taken.
// Reset is synchronous and restores the configuration defaults and a hunting
// header section. A stalled result holds both registers until out_ready.
`timescale 1ns / 1ps

module pdu_stream_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  byte_value,
  output logic        header_done,
  output logic [7:0]  command,
  output logic [31:0] request_id,
  output logic [31:0] data_length,
  output logic [11:0] sig_length,
  output logic [3:0]  sig_alg,
  output logic [9:0]  option_bytes,
  output logic [7:0]  flags,
  output logic [1:0]  error_code,
  output logic        last_of_pdu,
  input  logic        cfg_write,
  input  logic [pdu_dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdu_dfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  pdu_dfr_pkg::cfg_t    cfg;
  pdu_dfr_pkg::result_t res;
  pdu_dfr_pkg::result_t out_res;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_version <= 8'd2;
      cfg.max_version <= 8'd4;
      cfg.recno_mask <= 8'd1;
      cfg.seqno_mask <= 8'd2;
      cfg.time_mask <= 8'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pdu_dfr_pkg::REG_MIN_VERSION: cfg.min_version <= cfg_data;
        pdu_dfr_pkg::REG_MAX_VERSION: cfg.max_version <= cfg_data;
        pdu_dfr_pkg::REG_RECNO_MASK:  cfg.recno_mask <= cfg_data;
        pdu_dfr_pkg::REG_SEQNO_MASK:  cfg.seqno_mask <= cfg_data;
        pdu_dfr_pkg::REG_TIME_MASK:   cfg.time_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  pdu_dfr_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign kind = out_res.kind;
  assign byte_value = out_res.byte_value;
  assign header_done = out_res.header_done;
  assign command = out_res.command;
  assign request_id = out_res.request_id;
  assign data_length = out_res.data_length;
  assign sig_length = out_res.sig_length;
  assign sig_alg = out_res.sig_alg;
  assign option_bytes = out_res.option_bytes;
  assign flags = out_res.flags;
  assign error_code = out_res.error_code;
  assign last_of_pdu = out_res.last_of_pdu;

endmodule

@@ test/tb_pdu_stream_deframer.sv @@
// Self-checking testbench for pdu_stream_deframer: directed PDUs, version and option overflow
// cases, then random framed traffic under sender gaps and receiver stalls.
// Depends on pdu_dfr_pkg and the deframer RTL; it predicts every result word on its own.
`timescale 1ns / 1ps

module tb_pdu_stream_deframer;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic        header_done;
  logic [7:0]  command;
  logic [31:0] request_id;
  logic [31:0] data_length;
  logic [11:0] sig_length;
  logic [3:0]  sig_alg;
  logic [9:0]  option_bytes;
  logic [7:0]  flags;
  logic [1:0]  error_code;
  logic        last_of_pdu;
  logic        cfg_write;
  logic [pdu_dfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pdu_dfr_pkg::CFG_DATA_W-1:0] cfg_data;

  pdu_stream_deframer DUT (.*);

  pdu_dfr_pkg::cfg_t     cfg_m;
  pdu_dfr_pkg::section_t sec_q;
  pdu_dfr_pkg::count_t   cnt_q;
  logic [7:0]  cmd_q;
  logic [31:0] rid_q;
  logic [15:0] sig_q;
  logic [7:0]  optw_q;
  logic [7:0]  flag_q;
  logic [31:0] dlen_q;
  logic        ovf_q;

  pdu_dfr_pkg::result_t framed_q[$];
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned sent_words;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned rx_mode;
  int unsigned rx_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic pdu_dfr_pkg::cfg_t make_cfg(logic [7:0] vmin, logic [7:0] vmax,
                                                 logic [7:0] rmask, logic [7:0] smask,
                                                 logic [7:0] tmask);
    pdu_dfr_pkg::cfg_t c;
    c.min_version = vmin;
    c.max_version = vmax;
    c.recno_mask = rmask;
    c.seqno_mask = smask;
    c.time_mask = tmask;
    return c;
  endfunction

  function automatic pdu_dfr_pkg::result_t with_header(pdu_dfr_pkg::result_t r);
    r.command = cmd_q;
    r.request_id = rid_q;
    r.data_length = dlen_q;
    r.sig_length = sig_q[11:0];
    r.sig_alg = sig_q[15:12];
    r.option_bytes = {optw_q, 2'b00};
    r.flags = flag_q;
    return r;
  endfunction

  // Moves past the given section to the next one that is not empty; returns 1 at end of PDU.
  function automatic logic step_past(pdu_dfr_pkg::section_t from);
    cnt_q = '0;
    if (from == pdu_dfr_pkg::SEC_HDR && optw_q != 0) begin
      sec_q = pdu_dfr_pkg::SEC_OPT;
      return 1'b0;
    end
    if ((from == pdu_dfr_pkg::SEC_HDR || from == pdu_dfr_pkg::SEC_OPT) && dlen_q != 0) begin
      sec_q = pdu_dfr_pkg::SEC_DATA;
      return 1'b0;
    end
    if (from != pdu_dfr_pkg::SEC_SIG && sig_q[11:0] != 0) begin
      sec_q = pdu_dfr_pkg::SEC_SIG;
      return 1'b0;
    end
    sec_q = pdu_dfr_pkg::SEC_HDR;
    return 1'b1;
  endfunction

  function automatic pdu_dfr_pkg::result_t deframe_byte(logic [7:0] b);
    pdu_dfr_pkg::result_t r;
    logic [5:0] need;
    r = '0;
    r.byte_value = b;
    case (sec_q)
      pdu_dfr_pkg::SEC_OPT: begin
        r.kind = pdu_dfr_pkg::KIND_OPT;
        r = with_header(r);
        if (64'(cnt_q) + 64'd1 >= 64'(optw_q) * 64'd4)
          r.last_of_pdu = step_past(pdu_dfr_pkg::SEC_OPT);
        else cnt_q++;
      end
      pdu_dfr_pkg::SEC_DATA: begin
        r.kind = pdu_dfr_pkg::KIND_DATA;
        r = with_header(r);
        if (64'(cnt_q) + 64'd1 >= 64'(dlen_q))
          r.last_of_pdu = step_past(pdu_dfr_pkg::SEC_DATA);
        else cnt_q++;
      end
      pdu_dfr_pkg::SEC_SIG: begin
        r.kind = pdu_dfr_pkg::KIND_SIG;
        r = with_header(r);
        if (64'(cnt_q) + 64'd1 >= 64'(sig_q[11:0]))
          r.last_of_pdu = step_past(pdu_dfr_pkg::SEC_SIG);
        else cnt_q++;
      end
      default: begin
        if (cnt_q >= pdu_dfr_pkg::FIXED_HEADER_BYTES) cnt_q = '0;
        if (cnt_q == 0) begin
          if (b < cfg_m.min_version || b > cfg_m.max_version) begin
            r.kind = pdu_dfr_pkg::KIND_DROP;
            r.error_code = pdu_dfr_pkg::ERR_VERSION;
            return r;
          end
          ovf_q = 1'b0;
        end
        r.kind = pdu_dfr_pkg::KIND_HDR;
        if (cnt_q == pdu_dfr_pkg::OFS_CMD) cmd_q = b;
        else if (cnt_q >= pdu_dfr_pkg::OFS_RID && cnt_q < pdu_dfr_pkg::OFS_RID + 4)
          rid_q = {rid_q[23:0], b};
        else if (cnt_q >= pdu_dfr_pkg::OFS_SIG && cnt_q < pdu_dfr_pkg::OFS_SIG + 2)
          sig_q = {sig_q[7:0], b};
        else if (cnt_q == pdu_dfr_pkg::OFS_OPT) optw_q = b;
        else if (cnt_q == pdu_dfr_pkg::OFS_FLAGS) flag_q = b;
        else if (cnt_q >= pdu_dfr_pkg::OFS_DLEN && cnt_q < pdu_dfr_pkg::OFS_DLEN + 4)
          dlen_q = {dlen_q[23:0], b};
        if (cnt_q + 1 >= pdu_dfr_pkg::FIXED_HEADER_BYTES) begin
          need = '0;
          if ((flag_q & cfg_m.seqno_mask) != 0) need += pdu_dfr_pkg::SEQNO_BYTES;
          if ((flag_q & cfg_m.recno_mask) != 0) need += pdu_dfr_pkg::RECNO_BYTES;
          if ((flag_q & cfg_m.time_mask) != 0) need += pdu_dfr_pkg::TIME_BYTES;
          ovf_q = ({optw_q, 2'b00} < 10'(need));
          r.header_done = 1'b1;
          r = with_header(r);
          if (ovf_q) r.error_code = pdu_dfr_pkg::ERR_OVERFLOW;
          r.last_of_pdu = step_past(pdu_dfr_pkg::SEC_HDR);
        end else begin
          cnt_q++;
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pdu_dfr_pkg::result_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (framed_q.size() == 0) begin
        if (errors < 40)
          $display("%0t: result word with nothing expected, expected none, actual byte %02h",
                   $time, byte_value);
        errors++;
      end else begin
        want = framed_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("byte_value", 32'(want.byte_value), 32'(byte_value));
        check_field("header_done", 32'(want.header_done), 32'(header_done));
        check_field("command", 32'(want.command), 32'(command));
        check_field("request_id", want.request_id, request_id);
        check_field("data_length", want.data_length, data_length);
        check_field("sig_length", 32'(want.sig_length), 32'(sig_length));
        check_field("sig_alg", 32'(want.sig_alg), 32'(sig_alg));
        check_field("option_bytes", 32'(want.option_bytes), 32'(option_bytes));
        check_field("flags", 32'(want.flags), 32'(flags));
        check_field("error_code", 32'(want.error_code), 32'(error_code));
        check_field("last_of_pdu", 32'(want.last_of_pdu), 32'(last_of_pdu));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches between random stall patterns and holds off on request.
  initial begin
    out_ready = 1'b0;
    hold_seen = 0;
    rx_left = 0;
    rx_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_left % 4 != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_word(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    framed_q.push_back(deframe_byte(b));
    sent_words++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [pdu_dfr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input pdu_dfr_pkg::cfg_t c);
    settle();
    put_reg(pdu_dfr_pkg::REG_MIN_VERSION, c.min_version);
    put_reg(pdu_dfr_pkg::REG_MAX_VERSION, c.max_version);
    put_reg(pdu_dfr_pkg::REG_RECNO_MASK, c.recno_mask);
    put_reg(pdu_dfr_pkg::REG_SEQNO_MASK, c.seqno_mask);
    put_reg(pdu_dfr_pkg::REG_TIME_MASK, c.time_mask);
    cfg_write <= 1'b0;
    cfg_m = c;
  endtask

  task automatic send_pdu(input logic [7:0] ver, input logic [7:0] cmd, input logic [31:0] rid,
                          input logic [15:0] sigw, input logic [7:0] optw, input logic [7:0] flg,
                          input logic [31:0] dlen, input int unsigned body_cap);
    logic [7:0] hdr [0:79];
    longint unsigned body;
    int unsigned i;
    for (i = 0; i < 80; i++) hdr[i] = 8'($urandom);
    hdr[0] = ver;
    hdr[pdu_dfr_pkg::OFS_CMD] = cmd;
    for (i = 0; i < 4; i++) begin
      hdr[pdu_dfr_pkg::OFS_RID + i] = 8'(rid >> (8 * (3 - i)));
      hdr[pdu_dfr_pkg::OFS_DLEN + i] = 8'(dlen >> (8 * (3 - i)));
    end
    hdr[pdu_dfr_pkg::OFS_SIG] = sigw[15:8];
    hdr[pdu_dfr_pkg::OFS_SIG + 1] = sigw[7:0];
    hdr[pdu_dfr_pkg::OFS_OPT] = optw;
    hdr[pdu_dfr_pkg::OFS_FLAGS] = flg;
    for (i = 0; i < 80; i++) send_word(hdr[i]);
    body = longint'(optw) * 4 + longint'(dlen) + longint'(sigw[11:0]);
    if (body > body_cap) body = body_cap;
    repeat (body) send_word(8'($urandom));
  endtask

  task automatic send_random_pdu();
    logic [7:0] optw;
    logic [31:0] dlen;
    logic [15:0] sigw;
    case ($urandom_range(0, 19))
      0: optw = 8'($urandom_range(17, 40));
      1, 2, 3, 4, 5: optw = 8'($urandom_range(7, 16));
      default: optw = 8'($urandom_range(0, 6));
    endcase
    dlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
    sigw = {4'($urandom), 12'($urandom_range(0, 5))};
    send_pdu(8'($urandom_range(cfg_m.min_version, cfg_m.max_version)), 8'($urandom),
             $urandom, sigw, optw, 8'($urandom), dlen, 60);
  endtask

  task automatic test_version_window();
    gaps_on = 1'b1;
    send_word(8'h00);
    send_word(8'h01);
    send_word(8'h05);
    send_word(8'hff);
    send_pdu(8'd4, 8'h22, 32'hdead_beef, 16'ha003, 8'd0, 8'h00, 32'd0, 100);
    send_word(8'h80);
    send_pdu(8'd3, 8'h33, 32'h0, 16'h0000, 8'd0, 8'h00, 32'd1, 100);
  endtask

  task automatic test_section_framing();
    gaps_on = 1'b0;
    send_pdu(8'd3, 8'h44, 32'hffff_ffff, 16'h5002, 8'd2, 8'h01, 32'd5, 100);
  endtask

  task automatic test_option_overflow();
    gaps_on = 1'b1;
    send_pdu(8'd2, 8'h01, 32'h0, 16'h0000, 8'd7, 8'h07, 32'd2, 100);
    send_pdu(8'd3, 8'h02, 32'h0, 16'h0001, 8'd8, 8'h07, 32'd0, 100);
    send_pdu(8'd4, 8'h03, 32'h0, 16'h0000, 8'd0, 8'hff, 32'd0, 100);
  endtask

  task automatic test_config_extremes();
    gaps_on = 1'b1;
    set_config(make_cfg(8'd200, 8'd100, 8'h01, 8'h02, 8'h04));
    send_word(8'h00);
    send_word(8'hff);
    send_word(8'd150);
    send_word(8'd100);
    send_word(8'd200);
    set_config(make_cfg(8'd0, 8'd0, 8'h80, 8'h80, 8'h80));
    send_word(8'h01);
    send_pdu(8'd0, 8'hff, 32'h0, 16'h0000, 8'd7, 8'h80, 32'd1, 100);
    set_config(make_cfg(8'd255, 8'd255, 8'h00, 8'h00, 8'h00));
    send_word(8'hfe);
    send_pdu(8'd255, 8'h5a, 32'h0, 16'h0002, 8'd0, 8'hff, 32'd0, 100);
  endtask

  task automatic test_random_traffic();
    int unsigned p;
    int unsigned quota;
    logic [7:0] vlo;
    logic [7:0] vhi;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: set_config(make_cfg(8'd0, 8'd255, 8'h01 << $urandom_range(0, 7),
                               8'h01 << $urandom_range(0, 7), 8'h01 << $urandom_range(0, 7)));
        1: begin
          vlo = 8'($urandom);
          set_config(make_cfg(vlo, vlo, 8'h00, 8'h00, 8'h00));
        end
        2: set_config(make_cfg(8'd1, 8'd254, 8'hff, 8'hff, 8'hff));
        default: begin
          vlo = 8'($urandom_range(1, 200));
          vhi = 8'($urandom_range(vlo, 254));
          set_config(make_cfg(vlo, vhi, 8'($urandom), 8'($urandom), 8'($urandom)));
        end
      endcase
      gaps_on = (p != 2);
      quota = sent_words + 1;
      while (sent_words < quota) begin
        if (!(cfg_m.min_version == 0 && cfg_m.max_version == 255) &&
            $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            if (cfg_m.min_version > 0)
              send_word(8'($urandom_range(0, cfg_m.min_version - 1)));
            else send_word(8'($urandom_range(cfg_m.max_version + 1, 255)));
          end
        end
        send_random_pdu();
      end
    end
  endtask

  task automatic test_backpressure();
    set_config(make_cfg(8'd2, 8'd4, 8'h01, 8'h02, 8'h04));
    gaps_on = 1'b0;
    hold_req++;
    send_pdu(8'd3, 8'h99, 32'h0bad_f00d, 16'h3004, 8'd4, 8'h03, 32'd10, 200);
    send_pdu(8'd2, 8'h98, 32'h0, 16'h0000, 8'd0, 8'h00, 32'd20, 10);
    // Pause in the middle of the data block until the block has drained.
    settle();
    gaps_on = 1'b1;
    repeat (10) send_word(8'($urandom));
  endtask

  task automatic test_long_lengths();
    set_config(make_cfg(8'd0, 8'd255, 8'h01, 8'h02, 8'h04));
    gaps_on = 1'b1;
    send_pdu(8'd255, 8'hff, 32'hffff_ffff, 16'hffff, 8'd255, 8'hff, 32'hffff_ffff, 10);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycle_count = 0;
    sent_words = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_req = 0;
    cfg_m = make_cfg(8'd2, 8'd4, 8'h01, 8'h02, 8'h04);
    sec_q = pdu_dfr_pkg::SEC_HDR;
    cnt_q = '0;
    cmd_q = '0;
    rid_q = '0;
    sig_q = '0;
    optw_q = '0;
    flag_q = '0;
    dlen_q = '0;
    ovf_q = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_version_window();
    test_section_framing();
    test_option_overflow();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    test_long_lengths();
    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
